### hdl/sbt_pkg.sv
package sbt_pkg;

    // Width of the byte offset counters; offsets and lengths leave in 16 bits.
    localparam int OFFSET_BITS = 16;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // Scanner modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_STRING = 2'd2;

    // Token kinds
    localparam logic [2:0] KIND_LPAREN = 3'd0;
    localparam logic [2:0] KIND_RPAREN = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_IDENT  = 3'd3;
    localparam logic [2:0] KIND_EOF    = 3'd4;

    // Byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } token_t;

    // Low 16 bits of an offset, zero-extended when the counter is narrower.
    function automatic logic [15:0] fit16(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+15:0] t;
        t = {16'b0, v};
        return t[15:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] offset_inc(
        input logic [OFFSET_BITS-1:0] v);
        return (v == OFFSET_MAX) ? v : v + 1'b1;
    endfunction

endpackage

### hdl/sexpr_byte_tokenizer.sv
// S-expression byte tokenizer.
// Slave channel (s_*): one source text byte per transaction in s_tdata; a zero
// byte marks end of input and restarts offset, line and column counting.
// Master channel (m_*): one token per transaction. m_tuser carries the token
// kind, m_tdata the offset, length, start line and start column, and m_tlast
// flags the final token caused by a given input byte.
// Each byte is decoded in the cycle it is accepted: scanner state updates at
// that edge and its 0, 1 or 2 tokens are written into a four-entry result
// queue, from whose registers the tokens are offered on m_* in order.
// One byte can be taken every cycle while s_tready is high; a byte that
// closes an identifier with a paren, or closes a token at end of input,
// yields two tokens, which leave on m_* one after the other. s_tready is high
// while the queue has room for two more tokens, which is set by the queue depth.
// When the receiver stalls, tokens wait in the queue and s_tready drops once
// fewer than two entries are free; nothing is lost or repeated.
// Reset empties the queue, returns the scanner to idle between tokens,
// clears the offsets and sets line and column to one.
module sexpr_byte_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] token_offset, [31:16] token_length,
                                   // [47:32] start_line, [63:48] start_column
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_run
);

    // Scanner state
    logic [1:0]                      mode_reg, mode_next;
    logic                            single_reg, single_next;
    logic [sbt_pkg::OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [sbt_pkg::OFFSET_BITS-1:0] open_offset_reg, open_offset_next;
    logic [15:0]                     line_reg, line_next;
    logic [15:0]                     column_reg, column_next;
    logic [15:0]                     open_line_reg, open_line_next;
    logic [15:0]                     open_column_reg, open_column_next;

    // Result queue
    sbt_pkg::token_t                 queue_reg [sbt_pkg::QUEUE_DEPTH];
    logic [sbt_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [sbt_pkg::QPTR_BITS:0]     count_reg, count_next;

    logic            s_fire, m_fire;
    logic [7:0]      c;
    logic            is_space, term_ident, delim_hit, handle_idle;
    logic            close_v, idle_v, eof_hit;
    sbt_pkg::token_t close_tok, idle_tok, push0, push1;
    logic [1:0]      push_n;
    logic [sbt_pkg::OFFSET_BITS-1:0] open_len;

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = (count_reg <= (sbt_pkg::QPTR_BITS+1)'(sbt_pkg::QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    assign c        = s_tdata;
    assign is_space = (c == sbt_pkg::CH_SPACE) || (c == sbt_pkg::CH_LF) ||
                      (c == sbt_pkg::CH_TAB) || (c == sbt_pkg::CH_VT) ||
                      (c == sbt_pkg::CH_FF);
    assign term_ident = (c == sbt_pkg::CH_NUL) || is_space ||
                        (c == sbt_pkg::CH_LPAREN) || (c == sbt_pkg::CH_RPAREN);
    assign delim_hit  = single_reg ? (c == sbt_pkg::CH_SQUOTE) : (c == sbt_pkg::CH_DQUOTE);
    assign open_len   = offset_reg - open_offset_reg;

    // Byte decode and state update
    always_comb
    begin
        mode_next        = mode_reg;
        single_next      = single_reg;
        open_offset_next = open_offset_reg;
        open_line_next   = open_line_reg;
        open_column_next = open_column_reg;
        close_v          = 1'b0;
        idle_v           = 1'b0;
        eof_hit          = 1'b0;
        handle_idle      = 1'b1;

        close_tok.kind   = sbt_pkg::KIND_STRING;
        close_tok.offset = sbt_pkg::fit16(open_offset_reg);
        close_tok.length = sbt_pkg::fit16(open_len);
        close_tok.line   = open_line_reg;
        close_tok.column = open_column_reg;
        close_tok.last   = 1'b1;

        idle_tok.kind    = sbt_pkg::KIND_EOF;
        idle_tok.offset  = sbt_pkg::fit16(offset_reg);
        idle_tok.length  = 16'd0;
        idle_tok.line    = line_reg;
        idle_tok.column  = column_reg;
        idle_tok.last    = 1'b1;

        case (mode_reg)
            sbt_pkg::MODE_STRING:
            begin
                if (delim_hit || (c == sbt_pkg::CH_NUL))
                begin
                    close_v     = 1'b1;
                    mode_next   = sbt_pkg::MODE_IDLE;
                    handle_idle = (c == sbt_pkg::CH_NUL);
                end
                else
                begin
                    handle_idle = 1'b0;
                end
            end
            sbt_pkg::MODE_IDENT:
            begin
                close_tok.kind = sbt_pkg::KIND_IDENT;
                if (term_ident)
                begin
                    close_v   = 1'b1;
                    mode_next = sbt_pkg::MODE_IDLE;
                end
                else
                begin
                    handle_idle = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (handle_idle)
        begin
            case (c)
                sbt_pkg::CH_NUL:
                begin
                    idle_v  = 1'b1;
                    eof_hit = 1'b1;
                end
                sbt_pkg::CH_LPAREN:
                begin
                    idle_v          = 1'b1;
                    idle_tok.kind   = sbt_pkg::KIND_LPAREN;
                    idle_tok.length = 16'd1;
                end
                sbt_pkg::CH_RPAREN:
                begin
                    idle_v          = 1'b1;
                    idle_tok.kind   = sbt_pkg::KIND_RPAREN;
                    idle_tok.length = 16'd1;
                end
                sbt_pkg::CH_DQUOTE, sbt_pkg::CH_SQUOTE:
                begin
                    mode_next        = sbt_pkg::MODE_STRING;
                    single_next      = (c == sbt_pkg::CH_SQUOTE);
                    open_offset_next = sbt_pkg::offset_inc(offset_reg);
                    open_line_next   = line_reg;
                    open_column_next = column_reg;
                end
                default:
                begin
                    if (!is_space)
                    begin
                        mode_next        = sbt_pkg::MODE_IDENT;
                        // a leading backslash is not content
                        open_offset_next = (c == sbt_pkg::CH_BSLASH) ?
                                           sbt_pkg::offset_inc(offset_reg) : offset_reg;
                        open_line_next   = line_reg;
                        open_column_next = column_reg;
                    end
                end
            endcase
        end

        // only the final token of this byte carries last
        close_tok.last = !idle_v;

        // position counters; end of input restarts them
        if (eof_hit)
        begin
            offset_next = '0;
            line_next   = 16'd1;
            column_next = 16'd1;
        end
        else
        begin
            offset_next = sbt_pkg::offset_inc(offset_reg);
            if (c == sbt_pkg::CH_LF)
            begin
                line_next   = (line_reg != sbt_pkg::POS_MAX) ? line_reg + 16'd1 : line_reg;
                column_next = 16'd1;
            end
            else
            begin
                line_next   = line_reg;
                column_next = (column_reg != sbt_pkg::POS_MAX) ?
                              column_reg + 16'd1 : column_reg;
            end
        end

        push0  = close_v ? close_tok : idle_tok;
        push1  = idle_tok;
        push_n = {1'b0, close_v} + {1'b0, idle_v};
    end

    always_comb
    begin
        count_next = count_reg;
        if (s_fire)
        begin
            count_next = count_next + {1'b0, push_n};
        end
        if (m_fire)
        begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= sbt_pkg::MODE_IDLE;
            single_reg      <= 1'b0;
            offset_reg      <= '0;
            open_offset_reg <= '0;
            line_reg        <= 16'd1;
            column_reg      <= 16'd1;
            open_line_reg   <= 16'd1;
            open_column_reg <= 16'd1;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                mode_reg        <= mode_next;
                single_reg      <= single_next;
                offset_reg      <= offset_next;
                open_offset_reg <= open_offset_next;
                line_reg        <= line_next;
                column_reg      <= column_next;
                open_line_reg   <= open_line_next;
                open_column_reg <= open_column_next;
                wr_ptr_reg      <= wr_ptr_reg + push_n;
            end
            if (m_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire && (push_n != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= push0;
        end
        if (s_fire && (push_n == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= push1;
        end
    end

    assign m_tuser = queue_reg[rd_ptr_reg].kind;
    assign m_tdata = {queue_reg[rd_ptr_reg].column, queue_reg[rd_ptr_reg].line,
                      queue_reg[rd_ptr_reg].length, queue_reg[rd_ptr_reg].offset};
    assign m_tlast = queue_reg[rd_ptr_reg].last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (sbt_pkg::QPTR_BITS+1)'(sbt_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tdata == sbt_pkg::CH_NUL)) |=>
        (offset_reg == '0) && (line_reg == 16'd1) && (column_reg == 16'd1) &&
        (mode_reg == sbt_pkg::MODE_IDLE))
        else $error("end of input did not restart the scanner");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == sbt_pkg::KIND_EOF)) |-> m_tlast)
        else $error("end-of-input token not marked last");

    a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sbt_pkg::MODE_IDLE) || (mode_reg == sbt_pkg::MODE_IDENT) ||
        (mode_reg == sbt_pkg::MODE_STRING))
        else $error("scanner mode corrupt");
`endif

endmodule
